### hw/rtl/sfd_pkg.sv
// Shared constants and codes for the stereo feedback delay.
// No dependencies; used by sfd_echo_lane and stereo_feedback_delay.
`default_nettype none

package sfd_pkg;

    localparam int SAMPLE_W             = 32;
    localparam int PCT_W                = 7;
    localparam int LEN_CFG_W            = 17;
    localparam int CFG_IDX_W            = 1;
    localparam int MAX_DELAY_FRAMES_DEF = 65536;

    // Feedback gain ceiling in percent.
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Reciprocal of 100 for 32-bit unsigned dividends: q = (n * M) >> 37.
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;

    // Reciprocal of 100 for dividends below 43699: q = (n * 5243) >> 19.
    localparam logic [12:0] DIV100_SMALL_MAGIC = 13'd5243;
    localparam int          DIV100_SMALL_SHIFT = 19;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_PERCENT = 1'b1;

    // Request kinds.
    localparam logic REQ_PROCESS = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_CLEAR,
        ST_DELIVER
    } t_state;

    // Handshake between the sequencer and one arithmetic lane.
    typedef struct packed {
        logic start;
    } t_lane_ctl;

    typedef struct packed {
        logic done;
    } t_lane_sts;

endpackage

`default_nettype wire

### hw/rtl/sfd_echo_lane.sv
// One channel of the echo arithmetic: stored * pct / 100 plus sample, saturated.
// Six-stage pipeline, at most two multipliers per stage. Depends on sfd_pkg.
`default_nettype none

module sfd_echo_lane (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire sfd_pkg::t_lane_ctl             i_ctl,
    input  wire logic signed [sfd_pkg::SAMPLE_W-1:0] i_stored,
    input  wire logic signed [sfd_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [sfd_pkg::PCT_W-1:0]      i_pct,
    output sfd_pkg::t_lane_sts                  o_sts,
    output logic signed [sfd_pkg::SAMPLE_W-1:0] o_sum
);

    localparam int LAT = 6;
    localparam int H_W = 25;

    logic [LAT-1:0] r_vld;

    // stage 0: magnitude and sign
    logic [31:0]        r_mag0;
    logic               r_neg0;
    logic signed [31:0] r_x0;
    // stage 1: quotient by 100 of the magnitude
    logic [H_W-1:0]     r_h1;
    logic [31:0]        r_mag1;
    logic               r_neg1;
    logic signed [31:0] r_x1;
    // stage 2: remainder
    logic [H_W-1:0]     r_h2;
    logic [6:0]         r_l2;
    logic               r_neg2;
    logic signed [31:0] r_x2;
    // stage 3: scale both parts by the gain
    logic [31:0]        r_a3;
    logic [13:0]        r_b3;
    logic               r_neg3;
    logic signed [31:0] r_x3;
    // stage 4: feedback magnitude
    logic [31:0]        r_fbm4;
    logic               r_neg4;
    logic signed [31:0] r_x4;
    // stage 5: saturated sum
    logic signed [31:0] r_sum5;

    logic [31:0]        w_mag;
    logic [63:0]        w_prod;
    logic [31:0]        w_h100;
    logic [31:0]        w_l;
    logic [31:0]        w_a;
    logic [13:0]        w_b;
    logic [26:0]        w_c;
    logic [31:0]        w_fbm;
    logic signed [33:0] w_fb;
    logic signed [33:0] w_s;
    logic signed [31:0] w_sat;

    always_comb begin
        w_mag  = i_stored[31] ? (~i_stored + 32'd1) : i_stored;
        w_prod = 64'(r_mag0) * 64'(sfd_pkg::DIV100_MAGIC);
        w_h100 = 32'(r_h1) * 32'd100;
        w_l    = r_mag1 - w_h100;
        w_a    = 32'(r_h2) * 32'(i_pct);
        w_b    = 14'(r_l2) * 14'(i_pct);
        w_c    = 27'(r_b3) * 27'(sfd_pkg::DIV100_SMALL_MAGIC);
        w_fbm  = r_a3 + 32'(w_c[sfd_pkg::DIV100_SMALL_SHIFT+6:sfd_pkg::DIV100_SMALL_SHIFT]);
        w_fb   = r_neg4 ? -$signed({2'b00, r_fbm4}) : $signed({2'b00, r_fbm4});
        w_s    = $signed({{2{r_x4[31]}}, r_x4}) + w_fb;
        if (w_s > 34'sd2147483647) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_s < -34'sd2147483648) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_s[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_ctl.start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mag0 <= w_mag;
            r_neg0 <= i_stored[31];
            r_x0   <= i_sample;
        end
        if (r_vld[0]) begin
            r_h1   <= w_prod[sfd_pkg::DIV100_SHIFT+H_W-1:sfd_pkg::DIV100_SHIFT];
            r_mag1 <= r_mag0;
            r_neg1 <= r_neg0;
            r_x1   <= r_x0;
        end
        if (r_vld[1]) begin
            r_h2   <= r_h1;
            r_l2   <= w_l[6:0];
            r_neg2 <= r_neg1;
            r_x2   <= r_x1;
        end
        if (r_vld[2]) begin
            r_a3   <= w_a;
            r_b3   <= w_b;
            r_neg3 <= r_neg2;
            r_x3   <= r_x2;
        end
        if (r_vld[3]) begin
            r_fbm4 <= w_fbm;
            r_neg4 <= r_neg3;
            r_x4   <= r_x3;
        end
        if (r_vld[4]) begin
            r_sum5 <= w_sat;
        end
    end

    assign o_sts.done = r_vld[LAT-1];
    assign o_sum      = r_sum5;

endmodule

`default_nettype wire

### hw/rtl/stereo_feedback_delay.sv
// Stereo feedback echo: top level with ring memory, sequencer and two lanes.
// Process request: ring read, both lanes, write-back, then the result register is loaded.
// Bypass (length 0) goes straight to delivery; a clear request first zeroes the first r_len frames.
// The ring memory has one read port and one write port; each lane is six-stage. Requests are taken only in idle.
// Reset (synchronous, active low) starts a sweep that zeroes all MAX_DELAY_FRAMES
// frames; no request is taken until it ends, configuration writes are.
`default_nettype none

module stereo_feedback_delay #(
    parameter int MAX_DELAY_FRAMES = sfd_pkg::MAX_DELAY_FRAMES_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // request channel
    input  wire                                      i_valid,
    output logic                                     o_ready,
    input  wire                                      i_req_type,
    input  wire logic signed [sfd_pkg::SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [sfd_pkg::SAMPLE_W-1:0] i_right_in,
    // result channel
    output logic                                     o_valid,
    input  wire                                      i_ready,
    output logic signed [sfd_pkg::SAMPLE_W-1:0]      o_left_out,
    output logic signed [sfd_pkg::SAMPLE_W-1:0]      o_right_out,
    // configuration channel
    input  wire                                      i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [sfd_pkg::LEN_CFG_W-1:0]       i_cfg_data
);

    localparam int SW     = sfd_pkg::SAMPLE_W;
    localparam int ADDR_W = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
    localparam int LEN_W  = $clog2(MAX_DELAY_FRAMES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DELAY_FRAMES - 1);

    // Ring memory: left sample in the upper half, right in the lower.
    logic [2*SW-1:0] mem [MAX_DELAY_FRAMES];
    logic [2*SW-1:0] r_rdata;

    sfd_pkg::t_state r_state, n_state;

    logic [LEN_W-1:0]          r_len;     // effective length, already saturated
    logic [sfd_pkg::PCT_W-1:0] r_pct;     // gain, already clamped
    logic [ADDR_W-1:0]         r_pos;
    logic [ADDR_W-1:0]         r_addr;    // sweep pointer for init and clear
    logic signed [SW-1:0]      r_x_l, r_x_r;
    logic signed [SW-1:0]      r_res_l, r_res_r;
    logic                      r_out_valid;
    logic signed [SW-1:0]      r_out_l, r_out_r;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_cfg_we;
    logic [ADDR_W-1:0]    w_eff_pos;
    logic [LEN_W-1:0]     w_pos_inc;
    logic [ADDR_W-1:0]    w_pos_next;
    logic                 w_sweep_last;
    logic                 w_clear_last;
    logic                 w_mem_re;
    logic                 w_mem_we;
    logic [ADDR_W-1:0]    w_mem_waddr;
    logic [2*SW-1:0]      w_mem_wdata;
    logic                 w_ready;

    sfd_pkg::t_lane_ctl   w_lane_ctl;
    sfd_pkg::t_lane_sts   w_sts_l, w_sts_r;
    logic signed [SW-1:0] w_sum_l, w_sum_r;

    // ---------------------------------------------------------------
    // Arithmetic lanes, one per channel; both run in lock step.
    // ---------------------------------------------------------------
    sfd_echo_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_stored (r_rdata[2*SW-1:SW]),
        .i_sample (r_x_l),
        .i_pct    (r_pct),
        .o_sts    (w_sts_l),
        .o_sum    (w_sum_l)
    );

    sfd_echo_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_stored (r_rdata[SW-1:0]),
        .i_sample (r_x_r),
        .i_pct    (r_pct),
        .o_sts    (w_sts_r),
        .o_sum    (w_sum_r)
    );

    // ---------------------------------------------------------------
    // Position arithmetic. The position stays below the length in normal
    // use; fall back to frame 0 if it ever does not.
    // ---------------------------------------------------------------
    always_comb begin
        w_eff_pos  = (LEN_W'(r_pos) < r_len) ? r_pos : '0;
        w_pos_inc  = LEN_W'(w_eff_pos) + LEN_W'(1);
        w_pos_next = (w_pos_inc >= r_len) ? '0 : ADDR_W'(w_pos_inc);
        w_sweep_last = (r_addr == LAST_ADDR);
        w_clear_last = (LEN_W'(r_addr) == (r_len - LEN_W'(1)));
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_accept   = i_valid && w_ready;
    assign w_cfg_we   = i_cfg_valid;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfd_pkg::ST_INIT: begin
                if (w_sweep_last) begin
                    n_state = sfd_pkg::ST_IDLE;
                end
            end
            sfd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == sfd_pkg::REQ_CLEAR) begin
                        n_state = (r_len != '0) ? sfd_pkg::ST_CLEAR : sfd_pkg::ST_DELIVER;
                    end else if (r_len != '0) begin
                        n_state = sfd_pkg::ST_READ;
                    end else begin
                        n_state = sfd_pkg::ST_DELIVER;
                    end
                end
            end
            sfd_pkg::ST_READ: begin
                n_state = sfd_pkg::ST_CALC;
            end
            sfd_pkg::ST_CALC: begin
                if (w_sts_l.done) begin
                    n_state = sfd_pkg::ST_DELIVER;
                end
            end
            sfd_pkg::ST_CLEAR: begin
                if (w_clear_last) begin
                    n_state = sfd_pkg::ST_DELIVER;
                end
            end
            sfd_pkg::ST_DELIVER: begin
                if (w_out_free) begin
                    n_state = sfd_pkg::ST_IDLE;
                end
            end
            default: n_state = sfd_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs (memory strobes, lane start, request ready)
    // ---------------------------------------------------------------
    always_comb begin
        w_ready          = 1'b0;
        w_mem_re         = 1'b0;
        w_mem_we         = 1'b0;
        w_mem_waddr      = r_addr;
        w_mem_wdata      = '0;
        w_lane_ctl.start = 1'b0;
        case (r_state)
            sfd_pkg::ST_INIT: begin
                w_mem_we = 1'b1;
            end
            sfd_pkg::ST_IDLE: begin
                w_ready  = 1'b1;
                // issue the read now so the stored frame lands in READ
                w_mem_re = i_valid && (i_req_type == sfd_pkg::REQ_PROCESS) && (r_len != '0);
            end
            sfd_pkg::ST_READ: begin
                w_lane_ctl.start = 1'b1;
            end
            sfd_pkg::ST_CALC: begin
                // write the new sums back at the frame just read
                w_mem_we    = w_sts_l.done;
                w_mem_waddr = w_eff_pos;
                w_mem_wdata = {w_sum_l, w_sum_r};
            end
            sfd_pkg::ST_CLEAR: begin
                w_mem_we = 1'b1;
            end
            sfd_pkg::ST_DELIVER: begin
                w_ready = 1'b0;
            end
            default: w_ready = 1'b0;
        endcase
    end

    assign o_ready     = w_ready;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Ring memory: one registered read port, one write port.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_rdata <= mem[w_eff_pos];
        end
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfd_pkg::ST_INIT;
            r_len       <= '0;
            r_pct       <= '0;
            r_pos       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // sweep pointer: advance through init and clear, rewind otherwise
            if ((r_state == sfd_pkg::ST_INIT) || (r_state == sfd_pkg::ST_CLEAR)) begin
                r_addr <= r_addr + ADDR_W'(1);
            end else begin
                r_addr <= '0;
            end

            // advance the ring once the frame is written back
            if ((r_state == sfd_pkg::ST_CALC) && w_sts_l.done) begin
                r_pos <= w_pos_next;
            end

            // result register: drop on take, load from DELIVER
            if ((r_state == sfd_pkg::ST_DELIVER) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_we) begin
                case (i_cfg_index)
                    sfd_pkg::CFG_DELAY_LENGTH: begin
                        if (32'(i_cfg_data) > 32'(MAX_DELAY_FRAMES)) begin
                            r_len <= LEN_W'(MAX_DELAY_FRAMES);
                        end else begin
                            r_len <= LEN_W'(i_cfg_data);
                        end
                        r_pos <= '0;
                    end
                    sfd_pkg::CFG_FEEDBACK_PERCENT: begin
                        if (i_cfg_data[sfd_pkg::PCT_W-1:0] > sfd_pkg::PCT_MAX) begin
                            r_pct <= sfd_pkg::PCT_MAX;
                        end else begin
                            r_pct <= i_cfg_data[sfd_pkg::PCT_W-1:0];
                        end
                    end
                    default: r_pct <= r_pct;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers (no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x_l <= i_left_in;
            r_x_r <= i_right_in;
            // bypass passes the samples through, clear answers with silence
            if (i_req_type == sfd_pkg::REQ_CLEAR) begin
                r_res_l <= '0;
                r_res_r <= '0;
            end else begin
                r_res_l <= i_left_in;
                r_res_r <= i_right_in;
            end
        end else if ((r_state == sfd_pkg::ST_CALC) && w_sts_l.done) begin
            r_res_l <= w_sum_l;
            r_res_r <= w_sum_r;
        end
        if ((r_state == sfd_pkg::ST_DELIVER) && w_out_free) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> (LEN_W'(r_pos) < r_len))
        else $error("ring position reached the delay length");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sts_l.done || w_sts_r.done) |->
            (w_sts_l.done && w_sts_r.done && (r_state == sfd_pkg::ST_CALC)))
        else $error("lane completion outside the calculation phase");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_re |=> (r_state == sfd_pkg::ST_READ))
        else $error("ring read issued without a process phase");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfd_pkg::ST_DELIVER && r_out_valid && !i_ready) |=>
            (r_state == sfd_pkg::ST_DELIVER && $stable(r_out_l)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
